[rtl/core/mucn_pkg.sv]
package mucn_pkg;

  localparam int COORD_W          = 32;
  localparam int NORM_W           = 18;
  localparam int FRAC_W           = 16;
  localparam int QUO_W            = FRAC_W + 1;
  localparam int EXT_W            = COORD_W;
  localparam int NUM_W            = COORD_W + 2;
  localparam int REM_W            = COORD_W + 1;
  localparam int DCNT_W           = $clog2(QUO_W);
  localparam int NORM_ONE         = 2 ** FRAC_W;
  localparam int MAX_VERTICES_DEF = 64;

  typedef enum logic [2:0] {
    S_LOAD,
    S_EXT,
    S_MAX,
    S_READ,
    S_NUM,
    S_ABS,
    S_DIV,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic ext_en;
    logic max_en;
    logic rd_en;
    logic num_en;
    logic abs_en;
    logic div_step;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic drain_last;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

[rtl/core/mucn_if.sv]
interface mucn_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mucn_pkg::COORD_W-1:0]  x_coord;
  logic signed [mucn_pkg::COORD_W-1:0]  y_coord;
  logic signed [mucn_pkg::COORD_W-1:0]  z_coord;
  logic                                 last_vertex;

  modport source (output valid, x_coord, y_coord, z_coord, last_vertex, input ready);
  modport sink   (input valid, x_coord, y_coord, z_coord, last_vertex, output ready);
endinterface

interface mucn_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mucn_pkg::NORM_W-1:0]  x_norm;
  logic signed [mucn_pkg::NORM_W-1:0]  y_norm;
  logic signed [mucn_pkg::NORM_W-1:0]  z_norm;
  logic                                end_of_mesh;

  modport source (output valid, x_norm, y_norm, z_norm, end_of_mesh, input ready);
  modport sink   (input valid, x_norm, y_norm, z_norm, end_of_mesh, output ready);
endinterface

[rtl/core/mucn_lane.sv]
module mucn_lane (
  input  logic                                clk,
  input  mucn_pkg::cmd_t                      cmd,
  input  logic                                first,
  input  logic signed [mucn_pkg::COORD_W-1:0] coord,
  input  logic signed [mucn_pkg::COORD_W-1:0] rd_coord,
  input  logic        [mucn_pkg::EXT_W-1:0]   ext_all,
  output logic        [mucn_pkg::EXT_W-1:0]   ext_axis,
  output logic signed [mucn_pkg::NORM_W-1:0]  norm
);
  import mucn_pkg::*;

  logic signed [COORD_W-1:0] min_r;
  logic signed [COORD_W-1:0] max_r;
  logic [EXT_W-1:0]          ext_r;
  logic [COORD_W:0]          sum_r;
  logic [NUM_W-1:0]          num_r;
  logic                      neg_r;
  logic [REM_W-1:0]          rem_r;
  logic [QUO_W-1:0]          quo_r;

  logic [COORD_W:0]          ext_diff;
  logic [COORD_W:0]          sum_nxt;
  logic [NUM_W-1:0]          num_nxt;
  logic [NUM_W-1:0]          num_mag;
  logic [REM_W:0]            trial;
  logic                      take;
  logic [NORM_W-1:0]         quo_ext;

  assign ext_diff = {max_r[COORD_W-1], max_r} - {min_r[COORD_W-1], min_r};
  assign sum_nxt  = {max_r[COORD_W-1], max_r} + {min_r[COORD_W-1], min_r};
  assign num_nxt  = {rd_coord[COORD_W-1], rd_coord, 1'b0} - {sum_r[COORD_W], sum_r};
  assign num_mag  = num_r[NUM_W-1] ? (~num_r + NUM_W'(1)) : num_r;
  assign trial    = {1'b0, rem_r} - {2'b00, ext_all};
  assign take     = ~trial[REM_W];
  assign quo_ext  = {1'b0, quo_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (first || (coord < min_r)) min_r <= coord;
      if (first || (coord > max_r)) max_r <= coord;
    end
    if (cmd.ext_en) begin
      ext_r <= ext_diff[EXT_W-1:0];
      sum_r <= sum_nxt;
    end
    if (cmd.num_en) num_r <= num_nxt;
    if (cmd.abs_en) begin
      neg_r <= num_r[NUM_W-1];
      rem_r <= num_mag[REM_W-1:0];
      quo_r <= '0;
    end else if (cmd.div_step) begin
      // remainder stays below the extent after each step, so 32 bits survive the shift
      rem_r <= take ? {trial[COORD_W-1:0], 1'b0} : {rem_r[COORD_W-1:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], take};
    end
  end

  assign ext_axis = ext_r;
  assign norm     = (ext_all == '0) ? '0 : (neg_r ? (~quo_ext + NORM_W'(1)) : quo_ext);

endmodule

[rtl/core/mucn_dp.sv]
module mucn_dp #(
  parameter int MAX_VERTICES = mucn_pkg::MAX_VERTICES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mucn_pkg::cmd_t                      cmd,
  output mucn_pkg::sts_t                      sts,
  input  logic signed [mucn_pkg::COORD_W-1:0] x_coord,
  input  logic signed [mucn_pkg::COORD_W-1:0] y_coord,
  input  logic signed [mucn_pkg::COORD_W-1:0] z_coord,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [mucn_pkg::NORM_W-1:0]  x_norm,
  output logic signed [mucn_pkg::NORM_W-1:0]  y_norm,
  output logic signed [mucn_pkg::NORM_W-1:0]  z_norm,
  output logic                                end_of_mesh
);
  import mucn_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int VW = 3 * COORD_W;

  logic [VW-1:0]      mem [MAX_VERTICES];
  logic [VW-1:0]      rd_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      idx_r;
  logic [CW-1:0]      idx_inc;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [EXT_W-1:0]   ext_all_r;
  logic [EXT_W-1:0]   ext_xy;
  logic [EXT_W-1:0]   ext_x, ext_y, ext_z;
  logic signed [NORM_W-1:0] nx, ny, nz;
  logic               out_valid_r;
  logic signed [NORM_W-1:0] x_norm_r, y_norm_r, z_norm_r;
  logic               end_r;
  logic               first;

  assign first   = (count_r == '0);
  assign idx_inc = idx_r + CW'(1);

  assign sts.full       = (count_r == CW'(MAX_VERTICES));
  assign sts.drain_last = (idx_inc == count_r);
  assign sts.div_done   = (dcnt_r == DCNT_W'(QUO_W - 1));
  assign sts.out_busy   = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load)  mem[count_r[AW-1:0]] <= {x_coord, y_coord, z_coord};
    if (cmd.rd_en) rd_r <= mem[idx_r[AW-1:0]];
  end

  mucn_lane u_lane_x (
    .clk      (clk),
    .cmd      (cmd),
    .first    (first),
    .coord    (x_coord),
    .rd_coord (rd_r[VW-1 -: COORD_W]),
    .ext_all  (ext_all_r),
    .ext_axis (ext_x),
    .norm     (nx)
  );

  mucn_lane u_lane_y (
    .clk      (clk),
    .cmd      (cmd),
    .first    (first),
    .coord    (y_coord),
    .rd_coord (rd_r[2*COORD_W-1 -: COORD_W]),
    .ext_all  (ext_all_r),
    .ext_axis (ext_y),
    .norm     (ny)
  );

  mucn_lane u_lane_z (
    .clk      (clk),
    .cmd      (cmd),
    .first    (first),
    .coord    (z_coord),
    .rd_coord (rd_r[COORD_W-1:0]),
    .ext_all  (ext_all_r),
    .ext_axis (ext_z),
    .norm     (nz)
  );

  assign ext_xy = (ext_y > ext_x) ? ext_y : ext_x;

  always_ff @(posedge clk) begin
    if (cmd.max_en) ext_all_r <= (ext_z > ext_xy) ? ext_z : ext_xy;
    if (cmd.push) begin
      x_norm_r <= nx;
      y_norm_r <= ny;
      z_norm_r <= nz;
      end_r    <= sts.drain_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) count_r <= count_r + CW'(1);
      if (cmd.abs_en) begin
        dcnt_r <= '0;
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r + DCNT_W'(1);
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
        if (sts.drain_last) begin
          idx_r   <= '0;
          count_r <= '0;
        end else begin
          idx_r <= idx_inc;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign x_norm      = x_norm_r;
  assign y_norm      = y_norm_r;
  assign z_norm      = z_norm_r;
  assign end_of_mesh = end_r;

endmodule

[rtl/core/mucn_ctrl.sv]
module mucn_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  input  mucn_pkg::sts_t sts,
  output mucn_pkg::cmd_t cmd
);
  import mucn_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = !sts.full;
          if (in_last) state_nxt = S_EXT;
        end
      end
      S_EXT: begin
        cmd.ext_en = 1'b1;
        state_nxt  = S_MAX;
      end
      S_MAX: begin
        cmd.max_en = 1'b1;
        state_nxt  = S_READ;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_NUM;
      end
      S_NUM: begin
        cmd.num_en = 1'b1;
        state_nxt  = S_ABS;
      end
      S_ABS: begin
        cmd.abs_en = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (!sts.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = sts.drain_last ? S_LOAD : S_READ;
        end
      end
    endcase
  end

endmodule

[rtl/core/mesh_unit_cube_normalizer_unit.sv]
// Mesh normalizer: vertices (signed Q16.16 x/y/z) are taken one per cycle and stored,
// up to MAX_VERTICES per mesh; extra vertices are dropped but a last flag on them still
// counts. After the vertex flagged last, the block computes the axis extents in S_EXT and S_MAX,
// then emits every stored vertex in arrival order as ((2*v - min - max) << 16) / extent,
// truncated toward zero, where extent is the largest axis extent (all zeros if that is
// 0). Each result takes a store read, centering, magnitude and a 17-step
// restoring divide at one quotient bit per cycle, one divider per axis. A one-entry
// output register lets the next result be computed while the current one waits; input
// is not taken until the last result of the mesh (end_of_mesh) is in that register.
module mesh_unit_cube_normalizer_unit #(
  parameter int MAX_VERTICES = mucn_pkg::MAX_VERTICES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mucn_in_if.sink     in_ch,
  mucn_out_if.source  out_ch
);
  import mucn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mucn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_vertex),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mucn_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .x_coord     (in_ch.x_coord),
    .y_coord     (in_ch.y_coord),
    .z_coord     (in_ch.z_coord),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .x_norm      (out_ch.x_norm),
    .y_norm      (out_ch.y_norm),
    .z_norm      (out_ch.z_norm),
    .end_of_mesh (out_ch.end_of_mesh)
  );

endmodule

[rtl/core/mucn_checker.sv]
module mucn_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_last,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [mucn_pkg::NORM_W-1:0] x_norm,
  input logic signed [mucn_pkg::NORM_W-1:0] y_norm,
  input logic signed [mucn_pkg::NORM_W-1:0] z_norm,
  input logic                               end_of_mesh
);
  import mucn_pkg::*;

  localparam logic signed [NORM_W-1:0] NORM_HI = NORM_W'(NORM_ONE);
  localparam logic signed [NORM_W-1:0] NORM_LO = -NORM_HI;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(x_norm) && $stable(y_norm)
      && $stable(z_norm) && $stable(end_of_mesh))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> x_norm >= NORM_LO && x_norm <= NORM_HI && y_norm >= NORM_LO
      && y_norm <= NORM_HI && z_norm >= NORM_LO && z_norm <= NORM_HI)
    else $error("normalized value outside unit range");

  a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken right after last vertex transaction");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind mesh_unit_cube_normalizer_unit mucn_checker u_mucn_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_last     (in_ch.last_vertex),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .x_norm      (out_ch.x_norm),
  .y_norm      (out_ch.y_norm),
  .z_norm      (out_ch.z_norm),
  .end_of_mesh (out_ch.end_of_mesh)
);

[verif/mesh_unit_cube_normalizer_unit_tb.sv]
module mesh_unit_cube_normalizer_unit_tb;
  import mucn_pkg::*;

  localparam int IDLE_PCT       = 17;
  localparam int RANDOM_ITEMS   = 200;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT_RESULT = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int NUM_ROWS       = 16;

  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;

  typedef enum int {CM_WIDE, CM_NEAR, CM_FLAT, CM_EDGE} coord_mode_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
    logic                      pin;
    int                        px;
    int                        py;
    int                        pz;
  } vertex_row_t;

  typedef struct {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic signed [NORM_W-1:0] z;
    logic                     eom;
  } norm_vertex_t;

  logic clk;
  logic rst_n;

  mucn_in_if  in_ch();
  mucn_out_if out_ch();

  mesh_unit_cube_normalizer_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // pinned rows carry literal expectations for the end-of-mesh result
  vertex_row_t dir_rows [NUM_ROWS] = '{
    '{32'sd1, 32'sd2, 32'sd3, 1'b1, 1'b1, 0, 0, 0},
    '{C_MIN, 32'sd0, 32'sd0, 1'b0, 1'b0, 0, 0, 0},
    '{C_MAX, 32'sd0, 32'sd0, 1'b1, 1'b1, NORM_ONE, 0, 0},
    '{32'sd5, C_MIN, 32'sd7, 1'b0, 1'b0, 0, 0, 0},
    '{32'sd5, C_MAX, 32'sd7, 1'b1, 1'b1, 0, NORM_ONE, 0},
    '{32'sd0, 32'sd0, C_MAX, 1'b0, 1'b0, 0, 0, 0},
    '{32'sd0, 32'sd0, C_MIN, 1'b1, 1'b1, 0, 0, -NORM_ONE},
    '{32'sd7, 32'sd7, 32'sd7, 1'b0, 1'b0, 0, 0, 0},
    '{32'sd7, 32'sd7, 32'sd7, 1'b0, 1'b0, 0, 0, 0},
    '{32'sd7, 32'sd7, 32'sd7, 1'b1, 1'b1, 0, 0, 0},
    '{32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0, 0, 0, 0},
    '{32'sd1, -32'sd1, 32'sd2, 1'b0, 1'b0, 0, 0, 0},
    '{32'sd3, -32'sd3, 32'sd6, 1'b1, 1'b1, NORM_ONE / 2, -NORM_ONE / 2, NORM_ONE},
    '{C_MIN, C_MAX, -32'sd1, 1'b0, 1'b0, 0, 0, 0},
    '{C_MAX, C_MIN, 32'sd0, 1'b1, 1'b1, NORM_ONE, -NORM_ONE, 0},
    '{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f, 1'b1, 1'b1, 0, 0, 0}
  };

  logic signed [COORD_W-1:0] mesh_store [MAX_VERTICES_DEF][3];
  int                        mesh_count;
  longint                    bound_lo [3];
  longint                    bound_hi [3];
  norm_vertex_t              norm_q [$];

  int errors;
  int items_sent;
  int random_sent;
  int results_seen;
  int idle_cycles;

  function automatic logic signed [NORM_W-1:0] scale_coord(longint v, longint lo, longint hi,
                                                           longint extent);
    longint q;
    if (extent == 0) return '0;
    q = ((2 * v - lo - hi) * NORM_ONE) / extent;
    return q[NORM_W-1:0];
  endfunction

  function automatic void accept_vertex(input logic signed [COORD_W-1:0] v [3],
                                        input logic last);
    longint       extent;
    norm_vertex_t r;
    if (mesh_count < MAX_VERTICES_DEF) begin
      for (int a = 0; a < 3; a++) begin
        if (mesh_count == 0 || v[a] < bound_lo[a]) bound_lo[a] = v[a];
        if (mesh_count == 0 || v[a] > bound_hi[a]) bound_hi[a] = v[a];
        mesh_store[mesh_count][a] = v[a];
      end
      mesh_count++;
    end
    if (!last) return;
    extent = 0;
    for (int a = 0; a < 3; a++) begin
      if (bound_hi[a] - bound_lo[a] > extent) extent = bound_hi[a] - bound_lo[a];
    end
    for (int i = 0; i < mesh_count; i++) begin
      r.x   = scale_coord(mesh_store[i][0], bound_lo[0], bound_hi[0], extent);
      r.y   = scale_coord(mesh_store[i][1], bound_lo[1], bound_hi[1], extent);
      r.z   = scale_coord(mesh_store[i][2], bound_lo[2], bound_hi[2], extent);
      r.eom = (i == mesh_count - 1);
      norm_q.push_back(r);
    end
    mesh_count = 0;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord(coord_mode_t mode,
                                                           logic signed [COORD_W-1:0] center);
    case (mode)
      CM_WIDE: return $urandom;
      CM_NEAR: return center + int'($urandom_range(0, 511)) - 256;
      CM_FLAT: return center;
      default: begin
        case ($urandom_range(0, 4))
          0: return C_MIN;
          1: return C_MAX;
          2: return '0;
          3: return -1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic drive_vertex(input logic signed [COORD_W-1:0] v [3], input logic last);
    bit calm;
    calm = (items_sent >= 120 && items_sent < 200);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.x_coord     = v[0];
    in_ch.y_coord     = v[1];
    in_ch.z_coord     = v[2];
    in_ch.last_vertex = last;
    do @(posedge clk); while (!in_ch.ready);
    accept_vertex(v, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_mesh(input int len, input bit wide_only);
    coord_mode_t               mode [3];
    logic signed [COORD_W-1:0] center [3];
    logic signed [COORD_W-1:0] v [3];
    for (int a = 0; a < 3; a++) begin
      mode[a]   = wide_only ? CM_WIDE : coord_mode_t'($urandom_range(0, 3));
      center[a] = $urandom;
    end
    for (int i = 0; i < len; i++) begin
      for (int a = 0; a < 3; a++) v[a] = pick_coord(mode[a], center[a]);
      drive_vertex(v, i == len - 1);
    end
  endtask

  task automatic wait_all_results();
    in_ch.valid = 1'b0;
    while (norm_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    logic signed [COORD_W-1:0] v [3];
    int                        len;
    int                        meshes;
    int                        pick;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.x_coord     = '0;
    in_ch.y_coord     = '0;
    in_ch.z_coord     = '0;
    in_ch.last_vertex = 1'b0;
    errors            = 0;
    items_sent        = 0;
    random_sent       = 0;
    mesh_count        = 0;
    meshes            = 0;
    for (int a = 0; a < 3; a++) begin
      bound_lo[a] = 0;
      bound_hi[a] = 0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < NUM_ROWS; r++) begin
      v[0] = dir_rows[r].x;
      v[1] = dir_rows[r].y;
      v[2] = dir_rows[r].z;
      drive_vertex(v, dir_rows[r].last);
      if (dir_rows[r].pin) begin
        norm_q[norm_q.size()-1].x = NORM_W'(dir_rows[r].px);
        norm_q[norm_q.size()-1].y = NORM_W'(dir_rows[r].py);
        norm_q[norm_q.size()-1].z = NORM_W'(dir_rows[r].pz);
      end
    end
    wait_all_results();

    // full store, then overflow with last on a dropped vertex
    send_mesh(MAX_VERTICES_DEF, 1'b1);
    send_mesh(MAX_VERTICES_DEF + 6, 1'b1);

    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      len = $urandom_range(1, 8);
      else if (pick < 90) len = $urandom_range(9, 40);
      else if (pick < 96) len = $urandom_range(41, MAX_VERTICES_DEF);
      else                len = $urandom_range(MAX_VERTICES_DEF + 1, MAX_VERTICES_DEF + 6);
      send_mesh(len, 1'b0);
      random_sent += len;
      meshes++;
      if (meshes == 8) wait_all_results();
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    bit           held;
    bit           calm;
    norm_vertex_t exp_v;
    out_ch.ready = 1'b0;
    results_seen = 0;
    held         = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AT_RESULT) begin
        held         = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      calm = (results_seen >= 150 && results_seen < 260);
      out_ch.ready = rst_n && (calm || $urandom_range(0, 99) >= IDLE_PCT);
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (norm_q.size() == 0) begin
          $error("unexpected result x_norm %0d y_norm %0d z_norm %0d end_of_mesh %0b",
                 out_ch.x_norm, out_ch.y_norm, out_ch.z_norm, out_ch.end_of_mesh);
          errors++;
        end else begin
          exp_v = norm_q.pop_front();
          if (out_ch.x_norm !== exp_v.x) begin
            $error("x_norm expected %0d actual %0d", exp_v.x, out_ch.x_norm);
            errors++;
          end
          if (out_ch.y_norm !== exp_v.y) begin
            $error("y_norm expected %0d actual %0d", exp_v.y, out_ch.y_norm);
            errors++;
          end
          if (out_ch.z_norm !== exp_v.z) begin
            $error("z_norm expected %0d actual %0d", exp_v.z, out_ch.z_norm);
            errors++;
          end
          if (out_ch.end_of_mesh !== exp_v.eom) begin
            $error("end_of_mesh expected %0b actual %0b", exp_v.eom, out_ch.end_of_mesh);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule

[filelist.f]
rtl/core/mucn_pkg.sv
rtl/core/mucn_if.sv
rtl/core/mucn_lane.sv
rtl/core/mucn_dp.sv
rtl/core/mucn_ctrl.sv
rtl/core/mesh_unit_cube_normalizer_unit.sv
rtl/core/mucn_checker.sv
verif/mesh_unit_cube_normalizer_unit_tb.sv
